// ===== src/assert_macros.svh =====
// Assertion helpers shared by the front, queue and back-end RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define PRPM_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Condition must never be seen outside reset.
`define PRPM_NEVER(label, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) \
		else $error(msg);

`endif

// ===== src/prpm_pkg.sv =====
`default_nettype none
package prpm_pkg;
	localparam int MAX_SAMPLES = 1024;
	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int SAMPLE_W = 32;
	localparam int SUM_W = 64;
	localparam int Q31_W = 31;
	localparam int VGAIN_W = 19;
	localparam int CGAIN_W = 14;
	localparam int VMV_W = 21;
	localparam int CMA_W = 16;
	localparam int ACT_W = 39;
	localparam int APP_W = 38;
	localparam int PF_W = 11;
	localparam int GAIN_SHIFT = 29;
	localparam int PF_SCALE = 1000;
	localparam int FIFO_DEPTH = 2;
	localparam int LVL_W = $clog2(FIFO_DEPTH + 1);
	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 19;
	localparam int DIVISOR_W = 38;
	localparam int DIV_STEPS = 64;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS);
	localparam int SQ_STEPS = 31;
	localparam int SQ_CNT_W = $clog2(SQ_STEPS);

	localparam logic [VGAIN_W-1:0] VGAIN_RST = 19'd325269;
	localparam logic [CGAIN_W-1:0] CGAIN_RST = 14'd8485;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_VGAIN = 1'b0,
		REG_CGAIN = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [SUM_W-1:0] vsum;
		logic [SUM_W-1:0] isum;
		logic [SUM_W-1:0] psum;
		logic [CNT_W-1:0] n;
	} window_t;

	typedef struct packed {
		logic [LVL_W-1:0] level;
		logic             empty;
		logic             full;
	} fifo_stat_t;

	function automatic logic [Q31_W-1:0] sat_q31(input logic [SUM_W-1:0] quot);
		logic [Q31_W-1:0] r;
		if (quot[SUM_W-1] | quot[SUM_W-2]) begin
			r = '1;
		end else begin
			r = quot[SUM_W-3:Q31_W];
		end
		return r;
	endfunction
endpackage
`default_nettype wire

// ===== src/prpm_sample_if.sv =====
`default_nettype none
interface prpm_sample_if;
	logic                                   valid;
	logic                                   ready;
	logic signed [prpm_pkg::SAMPLE_W-1:0]  voltage_sample;
	logic signed [prpm_pkg::SAMPLE_W-1:0]  current_sample;
	logic                                   last_sample;

	modport source (output valid, voltage_sample, current_sample, last_sample, input ready);
	modport sink (input valid, voltage_sample, current_sample, last_sample, output ready);
endinterface
`default_nettype wire

// ===== src/prpm_result_if.sv =====
`default_nettype none
interface prpm_result_if;
	logic                               valid;
	logic                               ready;
	logic [prpm_pkg::VMV_W-1:0]        rms_voltage_mv;
	logic [prpm_pkg::CMA_W-1:0]        rms_current_ma;
	logic signed [prpm_pkg::ACT_W-1:0] active_power;
	logic [prpm_pkg::APP_W-1:0]        apparent_power;
	logic signed [prpm_pkg::PF_W-1:0]  power_factor;
	logic                               power_factor_invalid;

	modport source (output valid, rms_voltage_mv, rms_current_ma, active_power,
		apparent_power, power_factor, power_factor_invalid, input ready);
	modport sink (input valid, rms_voltage_mv, rms_current_ma, active_power,
		apparent_power, power_factor, power_factor_invalid, output ready);
endinterface
`default_nettype wire

// ===== src/prpm_front.sv =====
`default_nettype none
`include "assert_macros.svh"
module prpm_front (
	input  wire                  clk,
	input  wire                  arst_n,
	prpm_sample_if.sink          samp,
	input  prpm_pkg::fifo_stat_t stat,
	output logic                 push,
	output prpm_pkg::window_t    push_data
);
	logic [prpm_pkg::CNT_W-1:0]     cnt_q;
	logic [prpm_pkg::CNT_W-1:0]     n_next;
	logic                           close;
	logic                           accept;
	logic                           pend;
	logic [prpm_pkg::LVL_W:0]       need;
	logic signed [2*prpm_pkg::SAMPLE_W-1:0] vv;
	logic signed [2*prpm_pkg::SAMPLE_W-1:0] ii;
	logic signed [2*prpm_pkg::SAMPLE_W-1:0] vi;
	logic [prpm_pkg::SAMPLE_W-1:0]  pq;

	logic                           valid_s1;
	logic                           close_s1;
	logic [prpm_pkg::CNT_W-1:0]     n_s1;
	logic [prpm_pkg::SUM_W-1:0]     vv_s1;
	logic [prpm_pkg::SUM_W-1:0]     ii_s1;
	logic [prpm_pkg::SAMPLE_W-1:0]  pq_s1;

	logic [prpm_pkg::SUM_W-1:0]     vacc_q;
	logic [prpm_pkg::SUM_W-1:0]     iacc_q;
	logic [prpm_pkg::SUM_W-1:0]     pacc_q;
	logic [prpm_pkg::SUM_W-1:0]     vsum;
	logic [prpm_pkg::SUM_W-1:0]     isum;
	logic [prpm_pkg::SUM_W-1:0]     psum;

	assign n_next = cnt_q + prpm_pkg::CNT_W'(1);
	assign close  = samp.last_sample || (n_next == prpm_pkg::CNT_W'(prpm_pkg::MAX_SAMPLES));
	assign pend   = valid_s1 && close_s1;
	assign need   = {1'b0, stat.level} + (prpm_pkg::LVL_W + 1)'(pend);
	assign samp.ready = need < (prpm_pkg::LVL_W + 1)'(prpm_pkg::FIFO_DEPTH);
	assign accept = samp.valid && samp.ready;

	assign vv = samp.voltage_sample * samp.voltage_sample;
	assign ii = samp.current_sample * samp.current_sample;
	assign vi = samp.voltage_sample * samp.current_sample;

	always_comb begin
		if (!vi[2*prpm_pkg::SAMPLE_W-1] && vi[2*prpm_pkg::SAMPLE_W-2]) begin
			pq = {1'b0, {(prpm_pkg::SAMPLE_W-1){1'b1}}};
		end else begin
			pq = vi[2*prpm_pkg::SAMPLE_W-2:prpm_pkg::SAMPLE_W-1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				cnt_q <= close ? '0 : n_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			close_s1 <= close;
			n_s1     <= n_next;
			vv_s1    <= vv;
			ii_s1    <= ii;
			pq_s1    <= pq;
		end
	end

	assign vsum = vacc_q + vv_s1;
	assign isum = iacc_q + ii_s1;
	assign psum = pacc_q + {{(prpm_pkg::SUM_W-prpm_pkg::SAMPLE_W){pq_s1[prpm_pkg::SAMPLE_W-1]}},
		pq_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vacc_q <= '0;
			iacc_q <= '0;
			pacc_q <= '0;
		end else if (valid_s1) begin
			if (close_s1) begin
				vacc_q <= '0;
				iacc_q <= '0;
				pacc_q <= '0;
			end else begin
				vacc_q <= vsum;
				iacc_q <= isum;
				pacc_q <= psum;
			end
		end
	end

	assign push           = pend;
	assign push_data.vsum = vsum;
	assign push_data.isum = isum;
	assign push_data.psum = psum;
	assign push_data.n    = n_s1;

	`PRPM_ASSERT(a_cnt_bound, cnt_q < prpm_pkg::CNT_W'(prpm_pkg::MAX_SAMPLES), "count past window limit")
	`PRPM_NEVER(a_push_full, push && stat.full, "window pushed into full queue")
endmodule
`default_nettype wire

// ===== src/prpm_fifo.sv =====
`default_nettype none
`include "assert_macros.svh"
module prpm_fifo (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  push,
	input  prpm_pkg::window_t    push_data,
	input  wire                  pop,
	output logic                 pop_valid,
	output prpm_pkg::window_t    pop_data,
	output prpm_pkg::fifo_stat_t stat
);
	prpm_pkg::window_t              mem_q [prpm_pkg::FIFO_DEPTH];
	logic [prpm_pkg::PTR_W-1:0]     wr_q;
	logic [prpm_pkg::PTR_W-1:0]     rd_q;
	logic [prpm_pkg::LVL_W-1:0]     level_q;

	function automatic logic [prpm_pkg::PTR_W-1:0] bump(input logic [prpm_pkg::PTR_W-1:0] p);
		logic [prpm_pkg::PTR_W-1:0] r;
		if (p == prpm_pkg::PTR_W'(prpm_pkg::FIFO_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + prpm_pkg::PTR_W'(1);
		end
		return r;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push && !pop) begin
				level_q <= level_q + prpm_pkg::LVL_W'(1);
			end else if (pop && !push) begin
				level_q <= level_q - prpm_pkg::LVL_W'(1);
			end
		end
	end

	assign pop_valid  = level_q != '0;
	assign pop_data   = mem_q[rd_q];
	assign stat.level = level_q;
	assign stat.empty = level_q == '0;
	assign stat.full  = level_q == prpm_pkg::LVL_W'(prpm_pkg::FIFO_DEPTH);

	`PRPM_NEVER(a_pop_empty, pop && stat.empty, "pop from empty queue")
	`PRPM_ASSERT(a_level_bound, level_q <= prpm_pkg::LVL_W'(prpm_pkg::FIFO_DEPTH), "queue level overrun")
endmodule
`default_nettype wire

// ===== src/prpm_div.sv =====
`default_nettype none
module prpm_div (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                start,
	input  wire [prpm_pkg::SUM_W-1:0]          dividend,
	input  wire [prpm_pkg::DIVISOR_W-1:0]      divisor,
	output logic                               done,
	output logic [prpm_pkg::SUM_W-1:0]         quotient
);
	logic                               busy_q;
	logic                               done_q;
	logic [prpm_pkg::DIV_CNT_W-1:0]     cnt_q;
	logic [prpm_pkg::SUM_W-1:0]         dvd_q;
	logic [prpm_pkg::DIVISOR_W-1:0]     dvs_q;
	logic [prpm_pkg::DIVISOR_W:0]       rem_q;
	logic [prpm_pkg::DIVISOR_W:0]       rs;
	logic                               ge;

	assign rs = {rem_q[prpm_pkg::DIVISOR_W-1:0], dvd_q[prpm_pkg::SUM_W-1]};
	assign ge = rs >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + prpm_pkg::DIV_CNT_W'(1);
				if (cnt_q == prpm_pkg::DIV_CNT_W'(prpm_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			dvs_q <= divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rs - {1'b0, dvs_q} : rs;
			dvd_q <= {dvd_q[prpm_pkg::SUM_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = dvd_q;
endmodule
`default_nettype wire

// ===== src/prpm_back.sv =====
`default_nettype none
`include "assert_macros.svh"
module prpm_back (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             q_valid,
	input  prpm_pkg::window_t               q_data,
	output logic                            pop,
	input  wire [prpm_pkg::VGAIN_W-1:0]     vgain,
	input  wire [prpm_pkg::CGAIN_W-1:0]     cgain,
	prpm_result_if.source                   res
);
	typedef enum logic [10:0] {
		S_IDLE  = 11'b000_0000_0001,
		S_DIVV  = 11'b000_0000_0010,
		S_SQV   = 11'b000_0000_0100,
		S_DIVI  = 11'b000_0000_1000,
		S_SQI   = 11'b000_0001_0000,
		S_DIVP  = 11'b000_0010_0000,
		S_SCALE = 11'b000_0100_0000,
		S_ACT   = 11'b000_1000_0000,
		S_CLAMP = 11'b001_0000_0000,
		S_PFDIV = 11'b010_0000_0000,
		S_FIN   = 11'b100_0000_0000
	} back_state_t;

	localparam int SQX_W = 2 * prpm_pkg::Q31_W;
	localparam int SQR_W = prpm_pkg::Q31_W + 4;
	localparam int APPQ_W = prpm_pkg::VMV_W + prpm_pkg::CMA_W;
	localparam int GAINP_W = prpm_pkg::VGAIN_W + prpm_pkg::CGAIN_W;
	localparam int ACTP_W = 32 + GAINP_W;

	back_state_t                         state_q;
	prpm_pkg::window_t                   win_q;
	logic [SQX_W-1:0]                    sq_x_q;
	logic [SQR_W-1:0]                    sq_rem_q;
	logic [prpm_pkg::Q31_W-1:0]          sq_root_q;
	logic [prpm_pkg::SQ_CNT_W-1:0]       sq_cnt_q;
	logic [SQR_W-1:0]                    sq_rs;
	logic [SQR_W-1:0]                    sq_trial;
	logic                                sq_ge;
	logic [prpm_pkg::Q31_W-1:0]          sq_root_nx;
	logic                                sq_last;

	logic [prpm_pkg::Q31_W-1:0]          vr_q;
	logic [prpm_pkg::Q31_W-1:0]          cr_q;
	logic [31:0]                         mag_q;
	logic                                neg_q;
	logic [prpm_pkg::VMV_W-1:0]          vmv_q;
	logic [prpm_pkg::CMA_W-1:0]          cma_q;
	logic [GAINP_W-1:0]                  gain_q;
	logic [ACTP_W-1:0]                   actp_q;
	logic [APPQ_W-1:0]                   app_q;
	logic signed [prpm_pkg::ACT_W-1:0]   act_q;
	logic signed [prpm_pkg::PF_W-1:0]    pf_q;
	logic                                inv_q;

	logic [prpm_pkg::Q31_W+prpm_pkg::VGAIN_W-1:0] vprod;
	logic [prpm_pkg::Q31_W+prpm_pkg::CGAIN_W-1:0] cprod;
	logic [ACTP_W:0]                     ceil_sum;
	logic signed [prpm_pkg::ACT_W-1:0]   act_raw;
	logic signed [prpm_pkg::ACT_W-1:0]   act_clamp;
	logic signed [prpm_pkg::ACT_W-1:0]   app_s;
	logic [prpm_pkg::ACT_W-1:0]          act_mag;
	logic [prpm_pkg::SUM_W-1:0]          psum_mag;
	logic [prpm_pkg::PF_W-1:0]           pf_mag;

	logic                                div_start;
	logic [prpm_pkg::SUM_W-1:0]          div_dvd;
	logic [prpm_pkg::DIVISOR_W-1:0]      div_dvs;
	logic                                div_done;
	logic [prpm_pkg::SUM_W-1:0]          div_quot;

	logic                                ov_q;
	logic                                load;

	prpm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.done     (div_done),
		.quotient (div_quot)
	);

	assign sq_rs      = {sq_rem_q[SQR_W-3:0], sq_x_q[SQX_W-1:SQX_W-2]};
	assign sq_trial   = {2'b00, sq_root_q, 2'b01};
	assign sq_ge      = sq_rs >= sq_trial;
	assign sq_root_nx = {sq_root_q[prpm_pkg::Q31_W-2:0], sq_ge};
	assign sq_last    = sq_cnt_q == prpm_pkg::SQ_CNT_W'(prpm_pkg::SQ_STEPS - 1);

	assign psum_mag = win_q.psum[prpm_pkg::SUM_W-1] ? -win_q.psum : win_q.psum;

	assign vprod = {{prpm_pkg::VGAIN_W{1'b0}}, vr_q} * {{prpm_pkg::Q31_W{1'b0}}, vgain};
	assign cprod = {{prpm_pkg::CGAIN_W{1'b0}}, cr_q} * {{prpm_pkg::Q31_W{1'b0}}, cgain};

	assign ceil_sum = {1'b0, actp_q} + (ACTP_W + 1)'(2 ** prpm_pkg::GAIN_SHIFT - 1);
	assign act_raw  = neg_q ? -prpm_pkg::ACT_W'(ceil_sum >> prpm_pkg::GAIN_SHIFT)
		: prpm_pkg::ACT_W'(actp_q >> prpm_pkg::GAIN_SHIFT);
	assign app_s    = $signed({{(prpm_pkg::ACT_W-APPQ_W){1'b0}}, app_q});
	assign act_clamp = (act_raw > app_s) ? app_s : act_raw;
	assign act_mag  = act_clamp[prpm_pkg::ACT_W-1] ? -act_clamp : act_clamp;
	assign pf_mag   = (div_quot > prpm_pkg::SUM_W'(prpm_pkg::PF_SCALE))
		? prpm_pkg::PF_W'(prpm_pkg::PF_SCALE) : div_quot[prpm_pkg::PF_W-1:0];

	assign pop  = (state_q == S_IDLE) && q_valid;
	assign load = (state_q == S_FIN) && (!ov_q || res.ready);

	always_comb begin
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		unique case (state_q)
			S_IDLE: begin
				div_start = q_valid;
				div_dvd   = q_data.vsum;
				div_dvs   = prpm_pkg::DIVISOR_W'(q_data.n);
			end
			S_SQV: begin
				div_start = sq_last;
				div_dvd   = win_q.isum;
				div_dvs   = prpm_pkg::DIVISOR_W'(win_q.n);
			end
			S_SQI: begin
				div_start = sq_last;
				div_dvd   = psum_mag;
				div_dvs   = prpm_pkg::DIVISOR_W'(win_q.n);
			end
			S_CLAMP: begin
				div_start = app_q != '0;
				div_dvd   = prpm_pkg::SUM_W'(act_mag) * prpm_pkg::SUM_W'(prpm_pkg::PF_SCALE);
				div_dvs   = prpm_pkg::DIVISOR_W'(app_q);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (q_valid) state_q <= S_DIVV;
				S_DIVV:  if (div_done) state_q <= S_SQV;
				S_SQV:   if (sq_last) state_q <= S_DIVI;
				S_DIVI:  if (div_done) state_q <= S_SQI;
				S_SQI:   if (sq_last) state_q <= S_DIVP;
				S_DIVP:  if (div_done) state_q <= S_SCALE;
				S_SCALE: state_q <= S_ACT;
				S_ACT:   state_q <= S_CLAMP;
				S_CLAMP: state_q <= (app_q != '0) ? S_PFDIV : S_FIN;
				S_PFDIV: if (div_done) state_q <= S_FIN;
				S_FIN:   if (load) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			win_q <= q_data;
		end
		if (((state_q == S_DIVV) || (state_q == S_DIVI)) && div_done) begin
			sq_x_q    <= {prpm_pkg::sat_q31(div_quot), {prpm_pkg::Q31_W{1'b0}}};
			sq_rem_q  <= '0;
			sq_root_q <= '0;
			sq_cnt_q  <= '0;
		end else if ((state_q == S_SQV) || (state_q == S_SQI)) begin
			sq_rem_q  <= sq_ge ? sq_rs - sq_trial : sq_rs;
			sq_root_q <= sq_root_nx;
			sq_x_q    <= {sq_x_q[SQX_W-3:0], 2'b00};
			sq_cnt_q  <= sq_cnt_q + prpm_pkg::SQ_CNT_W'(1);
		end
		if ((state_q == S_SQV) && sq_last) begin
			vr_q <= sq_root_nx;
		end
		if ((state_q == S_SQI) && sq_last) begin
			cr_q  <= sq_root_nx;
			neg_q <= win_q.psum[prpm_pkg::SUM_W-1];
		end
		if ((state_q == S_DIVP) && div_done) begin
			mag_q <= div_quot[31:0];
		end
		if (state_q == S_SCALE) begin
			vmv_q  <= vprod[prpm_pkg::Q31_W+prpm_pkg::VGAIN_W-1:prpm_pkg::GAIN_SHIFT];
			cma_q  <= cprod[prpm_pkg::Q31_W+prpm_pkg::CGAIN_W-1:prpm_pkg::GAIN_SHIFT];
			gain_q <= GAINP_W'(vgain) * GAINP_W'(cgain);
		end
		if (state_q == S_ACT) begin
			actp_q <= ACTP_W'(mag_q) * ACTP_W'(gain_q);
			app_q  <= APPQ_W'(vmv_q) * APPQ_W'(cma_q);
		end
		if (state_q == S_ACT) begin
			inv_q <= 1'b0;
		end
		if (state_q == S_CLAMP) begin
			act_q <= act_clamp;
			inv_q <= app_q == '0;
			pf_q  <= '0;
		end
		if ((state_q == S_PFDIV) && div_done) begin
			pf_q <= act_q[prpm_pkg::ACT_W-1] ? -$signed(pf_mag) : $signed(pf_mag);
		end
		if (load) begin
			res.rms_voltage_mv       <= vmv_q;
			res.rms_current_ma       <= cma_q;
			res.active_power         <= act_q;
			res.apparent_power       <= prpm_pkg::APP_W'(app_q);
			res.power_factor         <= pf_q;
			res.power_factor_invalid <= inv_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (load) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	assign res.valid = ov_q;

	`PRPM_ASSERT(a_div_wait, div_done |-> (state_q == S_DIVV || state_q == S_DIVI
		|| state_q == S_DIVP || state_q == S_PFDIV), "divider finished outside a wait state")
endmodule
`default_nettype wire

// ===== src/phase_rms_power_meter_core.sv =====
// Throughput: one sample transaction per cycle inside a window while the window queue has room.
// Back end: a closed window passes through the window queue and then four 64-step divisions (three
//   when apparent power is zero) and two 31-step square roots before it reaches the result port.
// The two-entry window queue lets the front keep sampling; windows shorter than the back-end
//   time stall input once the queue fills.
// Reset: gains return to 325269 and 8485, sums and count clear, no clearing pass.
`default_nettype none
module phase_rms_power_meter_core (
	input  wire                                 clk,
	input  wire                                 arst_n,
	prpm_sample_if.sink                         samp,
	prpm_result_if.source                       res,
	input  wire                                 cfg_we,
	input  wire [prpm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [prpm_pkg::CFG_DATA_W-1:0]      cfg_data
);
	logic [prpm_pkg::VGAIN_W-1:0] vgain_q;
	logic [prpm_pkg::CGAIN_W-1:0] cgain_q;
	logic                         push;
	prpm_pkg::window_t            push_data;
	logic                         pop;
	logic                         pop_valid;
	prpm_pkg::window_t            pop_data;
	prpm_pkg::fifo_stat_t         stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vgain_q <= prpm_pkg::VGAIN_RST;
			cgain_q <= prpm_pkg::CGAIN_RST;
		end else if (cfg_we) begin
			unique case (prpm_pkg::cfg_reg_t'(cfg_index))
				prpm_pkg::REG_VGAIN: vgain_q <= cfg_data[prpm_pkg::VGAIN_W-1:0];
				prpm_pkg::REG_CGAIN: cgain_q <= cfg_data[prpm_pkg::CGAIN_W-1:0];
			endcase
		end
	end

	prpm_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.samp      (samp),
		.stat      (stat),
		.push      (push),
		.push_data (push_data)
	);

	prpm_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_valid (pop_valid),
		.pop_data  (pop_data),
		.stat      (stat)
	);

	prpm_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (pop_valid),
		.q_data  (pop_data),
		.pop     (pop),
		.vgain   (vgain_q),
		.cgain   (cgain_q),
		.res     (res)
	);
endmodule
`default_nettype wire
